/* rtl/hprd_pkg.sv */
// ----------------------------------------------------------------------------
// hprd_pkg
// Shared types, codes and helpers for the hex page record decoder.
// ----------------------------------------------------------------------------
package hprd_pkg;

   localparam int PAGE_BYTES_DEFAULT = 32;
   localparam int POS_W              = 6;
   localparam int COUNT_W            = 7;

   // input item kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // result item kinds
   localparam logic OUT_DATA   = 1'b0;
   localparam logic OUT_STATUS = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [1:0] STATUS_BAD_SUM  = 2'd2;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_F = 8'h66;
   localparam logic [7:0] PAD_BYTE   = 8'hff;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_code;
   } req_payload_type;

   typedef struct packed {
      logic             out_kind;
      logic [POS_W-1:0] position;
      logic [7:0]       data_byte;
      logic [1:0]       status;
      logic             last;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic accept_char;
      logic accept_end;
      logic load_pad;
      logic load_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic pad_none;
      logic pad_last;
   } sts_type;

   function automatic logic hex_is_digit(input logic [7:0] c);
      return ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) ||
             ((c >= CHAR_LOW_A) && (c <= CHAR_LOW_F));
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      if (c <= CHAR_NINE) begin
         v = c - CHAR_ZERO;
      end else begin
         v = c - CHAR_LOW_A + 8'd10;
      end
      return v[3:0];
   endfunction

endpackage

/* rtl/hex_page_record_decoder.sv */
// ----------------------------------------------------------------------------
// hex_page_record_decoder
// Decodes lowercase hex characters into page bytes with an xor checksum.
// ----------------------------------------------------------------------------
//  channel  direction  payload            transfer when
//  req      in         req_payload_type   req_valid && !req_stall
//  rsp      out        rsp_payload_type   rsp_valid && !rsp_stall
//
//  a new character is taken as soon as the result register is empty or
//  being drained in the same cycle.
//  an end item is followed by the padding bytes (up to PAGE_BYTES) and
//  then the status, each paced by the result register.
//  characters are held off (req_stall) during padding and status.
//  synchronous reset clears the sequencer, decoder state and result valid.
// ----------------------------------------------------------------------------
module hex_page_record_decoder
   import hprd_pkg::*;
#(
   parameter int PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   cmd_type cmd;
   sts_type sts;

   hprd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_payload.kind),
      .sts       (sts),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   hprd_datapath #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/hprd_ctrl.sv */
// ----------------------------------------------------------------------------
// hprd_ctrl
// Sequencer: takes characters in idle, then walks padding and status.
// ----------------------------------------------------------------------------
module hprd_ctrl
   import hprd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_kind,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    req_stall
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PAD    = 2'd1;
   localparam logic [1:0] ST_STATUS = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       take;

   assign take      = (state_ff == ST_IDLE) && sts.out_free;
   assign req_stall = !take;

   always_comb begin
      cmd.accept_char = take && req_valid && (req_kind == KIND_CHAR);
      cmd.accept_end  = take && req_valid && (req_kind == KIND_END);
      cmd.load_pad    = (state_ff == ST_PAD) && sts.out_free;
      cmd.load_status = (state_ff == ST_STATUS) && sts.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept_end) begin
               state_in = sts.pad_none ? ST_STATUS : ST_PAD;
            end
         end
         ST_PAD: begin
            if (cmd.load_pad && sts.pad_last) begin
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (cmd.load_status) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/hprd_datapath.sv */
// ----------------------------------------------------------------------------
// hprd_datapath
// Digit pairing, held byte, xor sum, pad counter and the result register.
// ----------------------------------------------------------------------------
module hprd_datapath
   import hprd_pkg::*;
#(
   parameter int PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   input  cmd_type         cmd,
   output sts_type         sts,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam logic [COUNT_W-1:0] MAX_BYTES = COUNT_W'(PAGE_BYTES + 1);
   localparam logic [COUNT_W-1:0] PAGE_CNT  = COUNT_W'(PAGE_BYTES);
   localparam logic [POS_W-1:0]   LAST_POS  = POS_W'(PAGE_BYTES - 1);

   logic               low_ff, low_in;
   logic [3:0]         high_ff, high_in;
   logic [7:0]         held_ff, held_in;
   logic               held_valid_ff, held_valid_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         xor_ff, xor_in;
   logic               error_ff, error_in;
   logic [POS_W-1:0]   pad_pos_ff, pad_pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   logic               bad_end;
   logic [COUNT_W-1:0] start_pos;
   logic [COUNT_W-1:0] emit_pos;
   logic [7:0]         new_byte;
   logic               char_live;
   logic               emit_char;
   logic [1:0]         final_status;

   assign bad_end   = error_ff || low_ff;
   assign start_pos = (count_ff == '0) ? '0 : count_ff - COUNT_W'(1);
   assign emit_pos  = count_ff - COUNT_W'(1);
   assign new_byte  = {high_ff, hex_nibble(req_payload.char_code)};
   assign char_live = cmd.accept_char && !error_ff && (count_ff < MAX_BYTES);
   assign emit_char = char_live && hex_is_digit(req_payload.char_code) && low_ff
                      && held_valid_ff;

   always_comb begin
      if (bad_end) begin
         final_status = STATUS_BAD_CHAR;
      end else if (xor_ff != ZERO_BYTE) begin
         final_status = STATUS_BAD_SUM;
      end else begin
         final_status = STATUS_OK;
      end
   end

   always_comb begin
      sts.out_free = !rsp_valid_ff || !rsp_stall;
      sts.pad_none = bad_end || (start_pos >= PAGE_CNT);
      sts.pad_last = (pad_pos_ff == LAST_POS);
   end

   // decoder state
   always_comb begin
      low_in        = low_ff;
      high_in       = high_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      count_in      = count_ff;
      xor_in        = xor_ff;
      error_in      = error_ff;
      pad_pos_in    = pad_pos_ff;
      priority if (cmd.load_status) begin
         low_in        = 1'b0;
         high_in       = '0;
         held_in       = '0;
         held_valid_in = 1'b0;
         count_in      = '0;
         xor_in        = '0;
         error_in      = 1'b0;
      end else if (cmd.load_pad) begin
         pad_pos_in = pad_pos_ff + POS_W'(1);
      end else if (cmd.accept_end) begin
         pad_pos_in = start_pos[POS_W-1:0];
      end else if (char_live) begin
         if (!hex_is_digit(req_payload.char_code)) begin
            error_in = 1'b1;
         end else if (!low_ff) begin
            high_in = hex_nibble(req_payload.char_code);
            low_in  = 1'b1;
         end else begin
            low_in        = 1'b0;
            xor_in        = xor_ff ^ new_byte;
            held_in       = new_byte;
            held_valid_in = 1'b1;
            count_in      = count_ff + COUNT_W'(1);
         end
      end
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      priority if (cmd.load_status) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_kind    = OUT_STATUS;
         rsp_in.position    = '0;
         rsp_in.data_byte   = ZERO_BYTE;
         rsp_in.status      = final_status;
         rsp_in.last        = 1'b1;
      end else if (cmd.load_pad) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_kind    = OUT_DATA;
         rsp_in.position    = pad_pos_ff;
         rsp_in.data_byte   = PAD_BYTE;
         rsp_in.status      = STATUS_OK;
         rsp_in.last        = 1'b0;
      end else if (emit_char) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_kind    = OUT_DATA;
         rsp_in.position    = emit_pos[POS_W-1:0];
         rsp_in.data_byte   = held_ff;
         rsp_in.status      = STATUS_OK;
         rsp_in.last        = 1'b0;
      end else begin
         rsp_in = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff        <= 1'b0;
         high_ff       <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
         xor_ff        <= '0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         low_ff        <= low_in;
         high_ff       <= high_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         count_ff      <= count_in;
         xor_ff        <= xor_in;
         error_ff      <= error_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pad_pos_ff <= pad_pos_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(cmd.load_pad || cmd.load_status || emit_char))
      else $error("result register loaded while stalled");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_BYTES)
      else $error("byte count beyond page plus checksum");

   a_status_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load_status |=> (count_ff == '0) && !error_ff && !low_ff && !held_valid_ff)
      else $error("decoder state not cleared after status");

   a_pad_in_page: assert property (@(posedge clock) disable iff (reset)
      cmd.load_pad |-> (pad_pos_ff <= LAST_POS))
      else $error("padding beyond last page position");

endmodule
